// ===== hw/rtl/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// bca_pkg: shared types and constants for the block-chain allocator
// Operation and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package bca_pkg;

    // default sizes
    localparam int NUM_BLOCKS_DEF = 256;
    localparam int NUM_FILES_DEF  = 16;
    localparam int BLOCK_BITS_DEF = 8;

    // fixed word field widths
    localparam int OP_W    = 3;
    localparam int FID_W   = 4;
    localparam int FIELD_W = 8;
    localparam int ST_W    = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC      = 3'd0,
        OP_LOCATE     = 3'd1,
        OP_SET_FIRST  = 3'd2,
        OP_GET_FIRST  = 3'd3,
        OP_WRITE_LINK = 3'd4,
        OP_READ_LINK  = 3'd5,
        OP_SET_HEAD   = 3'd6
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_ENDED = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,     // waiting for a word
        S_EXEC,     // decode, issue table access
        S_RDFIRST,  // first-block read data back
        S_WALK,     // chain walk, one link read per cycle
        S_RDLINK,   // link read data back
        S_PUSH      // hand result to output register
    } t_state;

endpackage

// ===== hw/rtl/bca_ram.sv =====
// ----------------------------------------------------------------------------
// bca_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/block_chain_allocator_top.sv =====
// ----------------------------------------------------------------------------
// A write-type word passes S_EXEC and S_PUSH; a read or allocate adds S_RDFIRST
// or S_RDLINK, a locate of index n S_RDFIRST and up to n S_WALK steps. A new word
// is taken only once the last has left S_PUSH. The chain walk does one link-table
// read per cycle through the single read port of the link RAM.
// Reset: synchronous, active low; free list empty, output register empty.
// Table contents are not cleared and are undefined until written.
// ----------------------------------------------------------------------------
// block_chain_allocator_top: block-chain table engine
// Link table, per-file first-block table and free-list head, driven by a
// small sequencer around two RAMs.
// ----------------------------------------------------------------------------
module block_chain_allocator_top
    import bca_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int NUM_FILES  = NUM_FILES_DEF,
    parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [OP_W-1:0]    i_operation,
    input  logic [FID_W-1:0]   i_file_id,
    input  logic [FIELD_W-1:0] i_block,
    input  logic [FIELD_W-1:0] i_count_or_link,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FIELD_W-1:0] o_result_block,
    output logic [ST_W-1:0]    o_status
);

    localparam int BB       = BLOCK_BITS;
    localparam int LA       = $clog2(NUM_BLOCKS);
    localparam int AW       = (BB > LA) ? BB : LA;
    localparam int RW       = (BB > FIELD_W) ? BB : FIELD_W;
    localparam int FT_DEPTH = (NUM_FILES < 2) ? 2 : NUM_FILES;
    localparam int FA       = $clog2(FT_DEPTH);
    localparam int FW       = (FA > FID_W) ? FA : FID_W;
    localparam int CMP_W    = 17;
    localparam logic [BB-1:0] INV_BLK = '1;

    // block value inside the link table
    function automatic logic blk_ok(input logic [BB-1:0] v);
        return CMP_W'(v) < CMP_W'(NUM_BLOCKS);
    endfunction

    // block value to link RAM address
    function automatic logic [LA-1:0] lk_addr(input logic [BB-1:0] v);
        logic [AW-1:0] t;
        t = AW'(v);
        return t[LA-1:0];
    endfunction

    // 8-bit field to block width
    function automatic logic [BB-1:0] to_blk(input logic [FIELD_W-1:0] v);
        logic [RW-1:0] t;
        t = RW'(v);
        return t[BB-1:0];
    endfunction

    // block width to 8-bit field
    function automatic logic [FIELD_W-1:0] to_field(input logic [BB-1:0] v);
        logic [RW-1:0] t;
        t = RW'(v);
        return t[FIELD_W-1:0];
    endfunction

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [FID_W-1:0]     r_fid, n_fid;
    logic [BB-1:0]        r_blk, n_blk;
    logic [FIELD_W-1:0]   r_arg, n_arg;    // link value, or remaining walk steps
    logic [BB-1:0]        r_cur, n_cur;
    logic [BB-1:0]        r_head, n_head;
    logic [BB-1:0]        r_res, n_res;
    t_status              r_st, n_st;
    logic                 r_out_valid;
    logic [FIELD_W-1:0]   r_out_res;
    t_status              r_out_st;

    logic                 lk_we;
    logic [LA-1:0]        lk_waddr, lk_raddr;
    logic [BB-1:0]        lk_wdata, lk_rdata;
    logic                 ft_we;
    logic [FA-1:0]        ft_addr;
    logic [BB-1:0]        ft_rdata;

    logic                 in_acc;
    logic                 out_free;
    logic                 out_load;
    logic                 fid_ok;
    logic                 arg_big;
    logic                 head_ok;
    logic [FW-1:0]        fid_w;
    logic [BB-1:0]        walk_v;
    logic                 walk_go;
    logic [BB-1:0]        arg_blk;

    // ---- tables ----
    bca_ram #(.WIDTH(BB), .DEPTH(NUM_BLOCKS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    bca_ram #(.WIDTH(BB), .DEPTH(FT_DEPTH)) u_first_ram (
        .i_clk   (i_clk),
        .i_we    (ft_we),
        .i_waddr (ft_addr),
        .i_wdata (r_blk),
        .i_raddr (ft_addr),
        .o_rdata (ft_rdata)
    );

    // ---- handshake ----
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (r_state == S_PUSH) && out_free;

    // ---- common decode ----
    assign fid_w   = FW'(r_fid);
    assign ft_addr = fid_w[FA-1:0];
    assign fid_ok  = (9'(r_fid) < 9'(NUM_FILES));
    assign arg_big = (CMP_W'(r_arg) > CMP_W'(NUM_BLOCKS));
    assign head_ok = (r_head != INV_BLK) && blk_ok(r_head);
    assign arg_blk = to_blk(r_arg);

    // walk operand: first block on the first step, then each link read
    assign walk_v  = (r_state == S_RDFIRST) ? ft_rdata : lk_rdata;
    assign walk_go = (r_arg != '0) && (walk_v != INV_BLK) && blk_ok(walk_v);

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ALLOC:     n_state = head_ok ? S_RDLINK : S_PUSH;
                    OP_LOCATE:    n_state = (fid_ok && !arg_big) ? S_RDFIRST : S_PUSH;
                    OP_GET_FIRST: n_state = fid_ok ? S_RDFIRST : S_PUSH;
                    OP_READ_LINK: n_state = blk_ok(r_blk) ? S_RDLINK : S_PUSH;
                    default:      n_state = S_PUSH;
                endcase
            end
            S_RDFIRST: begin
                if (r_op == OP_GET_FIRST) n_state = S_PUSH;
                else                      n_state = walk_go ? S_WALK : S_PUSH;
            end
            S_WALK:   n_state = walk_go ? S_WALK : S_PUSH;
            S_RDLINK: n_state = S_PUSH;
            S_PUSH: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // ---- datapath and table control ----
    always_comb begin
        n_op     = r_op;
        n_fid    = r_fid;
        n_blk    = r_blk;
        n_arg    = r_arg;
        n_cur    = r_cur;
        n_head   = r_head;
        n_res    = r_res;
        n_st     = r_st;
        lk_we    = 1'b0;
        lk_waddr = lk_addr(r_blk);
        lk_wdata = arg_blk;
        lk_raddr = lk_addr(r_blk);
        ft_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op  = t_op'(i_operation);
                    n_fid = i_file_id;
                    n_blk = to_blk(i_block);
                    n_arg = i_count_or_link;
                end
            end
            S_EXEC: begin
                n_res = INV_BLK;
                n_st  = ST_OK;
                unique case (r_op)
                    OP_ALLOC: begin
                        lk_raddr = lk_addr(r_head);
                        n_cur    = r_head;
                        if (!head_ok) n_st = ST_EMPTY;
                    end
                    OP_LOCATE: begin
                        // refused early: bad file, or index past the walk bound
                        n_st = ST_ENDED;
                    end
                    OP_SET_FIRST: begin
                        ft_we = fid_ok;
                        n_res = r_blk;
                    end
                    OP_GET_FIRST: begin
                        n_res = INV_BLK;
                    end
                    OP_WRITE_LINK: begin
                        lk_we = blk_ok(r_blk);
                        n_res = arg_blk;
                    end
                    OP_READ_LINK: begin
                        n_res = INV_BLK;
                    end
                    OP_SET_HEAD: begin
                        n_head = r_blk;
                        n_res  = r_blk;
                    end
                    default: begin
                        n_res = INV_BLK;
                    end
                endcase
            end
            S_RDFIRST, S_WALK: begin
                if (r_state == S_RDFIRST && r_op == OP_GET_FIRST) begin
                    n_res = ft_rdata;
                    n_st  = ST_OK;
                end else if (r_arg == '0) begin
                    // index reached
                    n_res = walk_v;
                    n_st  = (walk_v == INV_BLK) ? ST_ENDED : ST_OK;
                end else if (!walk_go) begin
                    // chain ended early
                    n_res = INV_BLK;
                    n_st  = ST_ENDED;
                end else begin
                    lk_raddr = lk_addr(walk_v);
                    n_arg    = r_arg - 1'b1;
                end
            end
            S_RDLINK: begin
                n_st = ST_OK;
                if (r_op == OP_ALLOC) begin
                    // pop: link becomes new head, popped block ends its chain
                    n_head   = lk_rdata;
                    lk_we    = 1'b1;
                    lk_waddr = lk_addr(r_cur);
                    lk_wdata = INV_BLK;
                    n_res    = r_cur;
                end else begin
                    n_res = lk_rdata;
                end
            end
            S_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= INV_BLK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_out_valid <= out_load || (r_out_valid && i_stall);
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_fid <= n_fid;
        r_blk <= n_blk;
        r_arg <= n_arg;
        r_cur <= n_cur;
        r_res <= n_res;
        r_st  <= n_st;
        if (out_load) begin
            r_out_res <= to_field(r_res);
            r_out_st  <= r_st;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_block = r_out_res;
    assign o_status       = r_out_st;

endmodule
